// ----- hdl/kdq_pkg.sv -----
// shared types and constants of the keyed delay queue
`default_nettype none

package kdq_pkg;

   localparam int KEY_W  = 32;
   localparam int TAG_W  = 16;
   localparam int TIME_W = 24;
   localparam int GAP_W  = 16;

   localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
   localparam logic [GAP_W-1:0]  GAP_RESET = 16'd1500;

   // csr address map: one register, paddr[2] selects the word
   localparam int         CSR_ADDR_W  = 3;
   localparam logic [0:0] CSR_GAP_IDX = 1'b0;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_TICK   = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED = 3'd0,
      ST_FULL     = 3'd1,
      ST_DUE      = 3'd2,
      ST_NONE     = 3'd3,
      ST_CLEARED  = 3'd4
   } status_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic [TIME_W-1:0] res;
      logic              le;
      logic              gt;
   } alu_out_type;

   typedef struct packed {
      logic              strobe;
      status_type        status;
      logic              due_class;
      logic [KEY_W-1:0]  key;
      logic [TAG_W-1:0]  tag;
      logic              last;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hdl/kdq_time_alu.sv -----
// shared time unit: saturating add of the gap, or subtract and compare
`default_nettype none

module kdq_time_alu (
   input  kdq_pkg::alu_op_type          op,
   input  logic [kdq_pkg::TIME_W-1:0]   a,
   input  logic [kdq_pkg::TIME_W-1:0]   b,
   input  logic [kdq_pkg::GAP_W-1:0]    gap,
   output kdq_pkg::alu_out_type         y
);

   logic [kdq_pkg::TIME_W:0]   opnd;
   logic [kdq_pkg::TIME_W:0]   sum;
   logic [kdq_pkg::TIME_W-1:0] sat;
   logic                       is_sub;

   assign is_sub = (op == kdq_pkg::ALU_SUB);

   // one 25-bit adder: a + gap, or a - b through the inverted operand
   assign opnd = is_sub ? ~{1'b0, b}
                        : {{(kdq_pkg::TIME_W + 1 - kdq_pkg::GAP_W){1'b0}}, gap};
   assign sum  = {1'b0, a} + opnd + {{kdq_pkg::TIME_W{1'b0}}, is_sub};

   assign sat = sum[kdq_pkg::TIME_W] ? kdq_pkg::TIME_MAX : sum[kdq_pkg::TIME_W-1:0];

   always_comb begin
      y.res = is_sub ? sum[kdq_pkg::TIME_W-1:0] : sat;
      // borrow out or zero difference means a <= b
      y.le  = sum[kdq_pkg::TIME_W] || (sum[kdq_pkg::TIME_W-1:0] == '0);
      y.gt  = (sat > b);
   end

endmodule

`default_nettype wire

// ----- hdl/kdq_ctrl.sv -----
// sequencer, entry table and order list of the keyed delay queue
`default_nettype none

module kdq_ctrl #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_type,
   input  logic                        req_entry_class,
   input  logic [kdq_pkg::KEY_W-1:0]   req_entry_key,
   input  logic [kdq_pkg::TAG_W-1:0]   req_entry_tag,
   input  logic [kdq_pkg::TIME_W-1:0]  req_delay_ms,
   input  logic [kdq_pkg::TIME_W-1:0]  req_elapsed_ms,
   input  logic [kdq_pkg::GAP_W-1:0]   gap,
   output kdq_pkg::rsp_type            rsp
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   typedef enum logic [4:0] {
      S_IDLE      = 5'b00001,
      S_INS_SCAN  = 5'b00010,
      S_INS_WRITE = 5'b00100,
      S_TICK_SCAN = 5'b01000,
      S_EMIT      = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // per-entry flags in flops
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [TABLE_DEPTH-1:0] kind_ff, kind_in;
   logic [TABLE_DEPTH-1:0] due_ff, due_in;

   // latched request
   logic                        op_cls_ff, op_cls_in;
   logic [kdq_pkg::KEY_W-1:0]   op_key_ff, op_key_in;
   logic [kdq_pkg::TAG_W-1:0]   op_tag_ff, op_tag_in;
   logic [kdq_pkg::TIME_W-1:0]  op_time_ff, op_time_in;

   logic [CNT_W-1:0] iss_ff, iss_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ndue_ff, ndue_in;
   logic [CNT_W-1:0] sent_ff, sent_in;
   logic [CNT_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic             rd_live_ff, rd_live_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             o_live_ff, o_live_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_slot_ff, free_slot_in;
   logic             pass_ff, pass_in;

   kdq_pkg::rsp_type rsp_ff, rsp_in;

   // entry memory: one write port, one registered read port
   logic [kdq_pkg::KEY_W-1:0]  key_mem  [TABLE_DEPTH];
   logic [kdq_pkg::TAG_W-1:0]  tag_mem  [TABLE_DEPTH];
   logic [kdq_pkg::TIME_W-1:0] time_mem [TABLE_DEPTH];
   logic [kdq_pkg::KEY_W-1:0]  ent_rkey_ff;
   logic [kdq_pkg::TAG_W-1:0]  ent_rtag_ff;
   logic [kdq_pkg::TIME_W-1:0] ent_rtime_ff;
   logic                       ent_we;
   logic [IDX_W-1:0]           ent_waddr;
   logic [IDX_W-1:0]           ent_raddr;
   logic [kdq_pkg::KEY_W-1:0]  ent_wkey;
   logic [kdq_pkg::TAG_W-1:0]  ent_wtag;
   logic [kdq_pkg::TIME_W-1:0] ent_wtime;

   // order list: slot numbers from oldest to newest
   logic [IDX_W-1:0] ord_mem [TABLE_DEPTH];
   logic [IDX_W-1:0] ord_rdata_ff;
   logic             ord_we;
   logic [IDX_W-1:0] ord_waddr;
   logic [IDX_W-1:0] ord_raddr;
   logic [IDX_W-1:0] ord_wdata;

   kdq_pkg::alu_op_type  alu_op;
   kdq_pkg::alu_out_type alu_y;

   logic             due_now;
   logic [IDX_W-1:0] slot;

   kdq_time_alu u_alu (
      .op  (alu_op),
      .a   (ent_rtime_ff),
      .b   (op_time_ff),
      .gap (gap),
      .y   (alu_y)
   );

   assign alu_op  = (state_ff == S_TICK_SCAN) ? kdq_pkg::ALU_SUB : kdq_pkg::ALU_ADD;
   assign due_now = valid_ff[rd_idx_ff] && alu_y.le;
   assign slot    = ord_rdata_ff;
   assign busy    = (state_ff != S_IDLE);
   assign rsp     = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      kind_in       = kind_ff;
      due_in        = due_ff;
      op_cls_in     = op_cls_ff;
      op_key_in     = op_key_ff;
      op_tag_in     = op_tag_ff;
      op_time_in    = op_time_ff;
      iss_in        = iss_ff;
      count_in      = count_ff;
      ndue_in       = ndue_ff;
      sent_in       = sent_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_live_in    = 1'b0;
      rd_idx_in     = iss_ff[IDX_W-1:0];
      o_live_in     = 1'b0;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      pass_in       = pass_ff;
      rsp_in        = '0;
      ent_we        = 1'b0;
      ent_waddr     = rd_idx_ff;
      ent_raddr     = iss_ff[IDX_W-1:0];
      ent_wkey      = ent_rkey_ff;
      ent_wtag      = ent_rtag_ff;
      ent_wtime     = alu_y.res;
      ord_we        = 1'b0;
      ord_waddr     = wr_ptr_ff[IDX_W-1:0];
      ord_raddr     = iss_ff[IDX_W-1:0];
      ord_wdata     = slot;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_cls_in     = req_entry_class;
               op_key_in     = req_entry_key;
               op_tag_in     = req_entry_tag;
               iss_in        = '0;
               free_found_in = 1'b0;
               ndue_in       = '0;
               sent_in       = '0;
               unique case (kdq_pkg::req_code_type'(req_type))
                  kdq_pkg::REQ_INSERT: begin
                     op_time_in = req_delay_ms;
                     state_in   = S_INS_SCAN;
                  end
                  kdq_pkg::REQ_TICK: begin
                     op_time_in = req_elapsed_ms;
                     state_in   = S_TICK_SCAN;
                  end
                  kdq_pkg::REQ_CLEAR: begin
                     valid_in      = '0;
                     count_in      = '0;
                     rsp_in.strobe = 1'b1;
                     rsp_in.status = kdq_pkg::ST_CLEARED;
                     rsp_in.last   = 1'b1;
                  end
                  kdq_pkg::REQ_NONE: begin
                  end
               endcase
            end
         end

         S_INS_SCAN: begin
            if (iss_ff != DEPTH_C) begin
               rd_live_in = 1'b1;
               iss_in     = iss_ff + CNT_W'(1);
            end
            if (rd_live_ff) begin
               if (valid_ff[rd_idx_ff]) begin
                  // same-key operation pending: push the delay past it plus the gap
                  if (op_cls_ff && kind_ff[rd_idx_ff] && (ent_rkey_ff == op_key_ff) &&
                      alu_y.gt) begin
                     op_time_in = alu_y.res;
                  end
               end else if (!free_found_ff) begin
                  free_found_in = 1'b1;
                  free_slot_in  = rd_idx_ff;
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = S_INS_WRITE;
               end
            end
         end

         S_INS_WRITE: begin
            state_in      = S_IDLE;
            rsp_in.strobe = 1'b1;
            rsp_in.last   = 1'b1;
            if (free_found_ff) begin
               ent_we                 = 1'b1;
               ent_waddr              = free_slot_ff;
               ent_wkey               = op_key_ff;
               ent_wtag               = op_tag_ff;
               ent_wtime              = op_time_ff;
               valid_in[free_slot_ff] = 1'b1;
               kind_in[free_slot_ff]  = op_cls_ff;
               ord_we                 = 1'b1;
               ord_waddr              = count_ff[IDX_W-1:0];
               ord_wdata              = free_slot_ff;
               count_in               = count_ff + CNT_W'(1);
               rsp_in.status          = kdq_pkg::ST_ACCEPTED;
            end else begin
               rsp_in.status = kdq_pkg::ST_FULL;
            end
         end

         S_TICK_SCAN: begin
            if (iss_ff != DEPTH_C) begin
               rd_live_in = 1'b1;
               iss_in     = iss_ff + CNT_W'(1);
            end
            if (rd_live_ff) begin
               due_in[rd_idx_ff] = due_now;
               ndue_in           = ndue_ff + CNT_W'(due_now);
               if (valid_ff[rd_idx_ff] && !due_now) begin
                  ent_we = 1'b1;
               end
               if (rd_idx_ff == LAST_IDX) begin
                  if (ndue_in == '0) begin
                     state_in      = S_IDLE;
                     rsp_in.strobe = 1'b1;
                     rsp_in.status = kdq_pkg::ST_NONE;
                     rsp_in.last   = 1'b1;
                  end else begin
                     state_in  = S_EMIT;
                     iss_in    = '0;
                     pass_in   = 1'b1;
                     wr_ptr_in = '0;
                  end
               end
            end
         end

         S_EMIT: begin
            // walk the order list: list read, then entry read, then transfer
            if (iss_ff != count_ff) begin
               o_live_in = 1'b1;
               ord_raddr = iss_ff[IDX_W-1:0];
               iss_in    = iss_ff + CNT_W'(1);
            end
            if (o_live_ff) begin
               if (due_ff[slot] && (kind_ff[slot] == pass_ff)) begin
                  ent_raddr  = slot;
                  rd_live_in = 1'b1;
               end
               // class-0 pass also compacts the list over the survivors
               if (!pass_ff && !due_ff[slot]) begin
                  ord_we    = 1'b1;
                  ord_waddr = wr_ptr_ff[IDX_W-1:0];
                  ord_wdata = slot;
                  wr_ptr_in = wr_ptr_ff + CNT_W'(1);
               end
            end
            if (rd_live_ff) begin
               rsp_in.strobe    = 1'b1;
               rsp_in.status    = kdq_pkg::ST_DUE;
               rsp_in.due_class = pass_ff;
               rsp_in.key       = ent_rkey_ff;
               rsp_in.tag       = ent_rtag_ff;
               rsp_in.last      = ((sent_ff + CNT_W'(1)) == ndue_ff);
               sent_in          = sent_ff + CNT_W'(1);
            end
            if ((iss_ff == count_ff) && !o_live_ff && !rd_live_ff) begin
               if (pass_ff) begin
                  pass_in = 1'b0;
                  iss_in  = '0;
               end else begin
                  valid_in = valid_ff & ~due_ff;
                  count_in = wr_ptr_ff;
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         valid_ff   <= '0;
         count_ff   <= '0;
         rd_live_ff <= 1'b0;
         o_live_ff  <= 1'b0;
         rsp_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         count_ff   <= count_in;
         rd_live_ff <= rd_live_in;
         o_live_ff  <= o_live_in;
         rsp_ff     <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      due_ff        <= due_in;
      op_cls_ff     <= op_cls_in;
      op_key_ff     <= op_key_in;
      op_tag_ff     <= op_tag_in;
      op_time_ff    <= op_time_in;
      iss_ff        <= iss_in;
      ndue_ff       <= ndue_in;
      sent_ff       <= sent_in;
      wr_ptr_ff     <= wr_ptr_in;
      rd_idx_ff     <= rd_idx_in;
      free_found_ff <= free_found_in;
      free_slot_ff  <= free_slot_in;
      pass_ff       <= pass_in;
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         key_mem[ent_waddr]  <= ent_wkey;
         tag_mem[ent_waddr]  <= ent_wtag;
         time_mem[ent_waddr] <= ent_wtime;
      end
      ent_rkey_ff  <= key_mem[ent_raddr];
      ent_rtag_ff  <= tag_mem[ent_raddr];
      ent_rtime_ff <= time_mem[ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (ord_we) begin
         ord_mem[ord_waddr] <= ord_wdata;
      end
      ord_rdata_ff <= ord_mem[ord_raddr];
   end

endmodule

`default_nettype wire

// ----- hdl/keyed_delay_queue_core.sv -----
// top level of the keyed delay queue: csr port and sequencer
//
//   channel   handshake                   payload
//   request   start / busy                req_type, req_entry_*, req_delay_ms, req_elapsed_ms
//   result    rsp_strobe (one cycle)      rsp_status, rsp_due_*, rsp_last_result
//   csr       psel/penable/pwrite/pready  paddr, pwdata, prdata (same_key_gap_ms at 0x0)
//
// with D = TABLE_DEPTH and N entries pending, an insert scans all D entries, then answers;
// a tick scans all D entries and, if any fall due, walks the N-entry order list twice
// a clear or an unknown code is taken in the idle state and never raises busy
// the entry memory has a single read port, so every scan visits one entry per cycle
// results come at most one per cycle and cannot be stalled
// synchronous reset empties the table and loads the gap with 1500; no clearing pass
`default_nettype none

module keyed_delay_queue_core #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_type,
   input  logic                                req_entry_class,
   input  logic [kdq_pkg::KEY_W-1:0]           req_entry_key,
   input  logic [kdq_pkg::TAG_W-1:0]           req_entry_tag,
   input  logic [kdq_pkg::TIME_W-1:0]          req_delay_ms,
   input  logic [kdq_pkg::TIME_W-1:0]          req_elapsed_ms,
   output logic                                rsp_strobe,
   output logic [2:0]                          rsp_status,
   output logic                                rsp_due_class,
   output logic [kdq_pkg::KEY_W-1:0]           rsp_due_key,
   output logic [kdq_pkg::TAG_W-1:0]           rsp_due_tag,
   output logic                                rsp_last_result,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [kdq_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   logic [kdq_pkg::GAP_W-1:0] gap_ff, gap_in;
   logic                      gap_sel;
   kdq_pkg::rsp_type          rsp;

   assign pready  = 1'b1;
   assign gap_sel = (paddr[kdq_pkg::CSR_ADDR_W-1:2] == kdq_pkg::CSR_GAP_IDX);

   always_comb begin
      gap_in = gap_ff;
      if (psel && penable && pwrite && gap_sel) begin
         gap_in = pwdata[kdq_pkg::GAP_W-1:0];
      end
      prdata = gap_sel ? {{(32 - kdq_pkg::GAP_W){1'b0}}, gap_ff} : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= kdq_pkg::GAP_RESET;
      end else begin
         gap_ff <= gap_in;
      end
   end

   kdq_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_entry_class (req_entry_class),
      .req_entry_key   (req_entry_key),
      .req_entry_tag   (req_entry_tag),
      .req_delay_ms    (req_delay_ms),
      .req_elapsed_ms  (req_elapsed_ms),
      .gap             (gap_ff),
      .rsp             (rsp)
   );

   assign rsp_strobe      = rsp.strobe;
   assign rsp_status      = rsp.status;
   assign rsp_due_class   = rsp.due_class;
   assign rsp_due_key     = rsp.key;
   assign rsp_due_tag     = rsp.tag;
   assign rsp_last_result = rsp.last;

endmodule

`default_nettype wire

// ----- tb/tb_keyed_delay_queue_core.sv -----
`timescale 1ns / 100ps
// self-checking testbench of the keyed delay queue core: directed table, then random phases
module tb_keyed_delay_queue_core;

   localparam int DEPTH         = 16;
   localparam int KEY_W         = kdq_pkg::KEY_W;
   localparam int TAG_W         = kdq_pkg::TAG_W;
   localparam int TIME_W        = kdq_pkg::TIME_W;
   localparam int GAP_W         = kdq_pkg::GAP_W;
   localparam int ADDR_W        = kdq_pkg::CSR_ADDR_W;
   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 64;
   localparam int CSR_PAD       = 24;
   localparam int PHASE_ITEMS   = 62;
   localparam int PHASES        = 5;
   localparam logic [ADDR_W-1:0] GAP_ADDR   = {kdq_pkg::CSR_GAP_IDX, 2'b00};
   localparam logic [ADDR_W-1:0] SPARE_ADDR = 3'd4;
   localparam logic [TIME_W-1:0] TIME_MAX   = kdq_pkg::TIME_MAX;

   typedef struct packed {
      kdq_pkg::req_code_type op;
      logic                  cls;
      logic [KEY_W-1:0]      key;
      logic [TAG_W-1:0]      tag;
      logic [TIME_W-1:0]     delay;
      logic [TIME_W-1:0]     elapsed;
   } req_item_type;

   typedef struct packed {
      kdq_pkg::status_type   status;
      logic                  cls;
      logic [KEY_W-1:0]      key;
      logic [TAG_W-1:0]      tag;
      logic                  last;
   } rsp_item_type;

   // typed_n: -1 use the predictor, 0 no result, 1 the one typed result
   typedef struct packed {
      req_item_type      req;
      int                reps;
      int                typed_n;
      rsp_item_type      rsp;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [1:0]            req_type;
   logic                  req_entry_class;
   logic [KEY_W-1:0]      req_entry_key;
   logic [TAG_W-1:0]      req_entry_tag;
   logic [TIME_W-1:0]     req_delay_ms;
   logic [TIME_W-1:0]     req_elapsed_ms;
   logic                  rsp_strobe;
   logic [2:0]            rsp_status;
   logic                  rsp_due_class;
   logic [KEY_W-1:0]      rsp_due_key;
   logic [TAG_W-1:0]      rsp_due_tag;
   logic                  rsp_last_result;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [ADDR_W-1:0]     paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   keyed_delay_queue_core #(.TABLE_DEPTH(DEPTH)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_entry_class(req_entry_class),
      .req_entry_key(req_entry_key), .req_entry_tag(req_entry_tag),
      .req_delay_ms(req_delay_ms), .req_elapsed_ms(req_elapsed_ms),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status), .rsp_due_class(rsp_due_class),
      .rsp_due_key(rsp_due_key), .rsp_due_tag(rsp_due_tag),
      .rsp_last_result(rsp_last_result),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the timer table and the gap register
   logic              shadow_valid [DEPTH];
   logic              shadow_kind  [DEPTH];
   logic [KEY_W-1:0]  shadow_key   [DEPTH];
   logic [TAG_W-1:0]  shadow_tag   [DEPTH];
   logic [TIME_W-1:0] shadow_left  [DEPTH];
   int                shadow_rank  [DEPTH];
   logic [GAP_W-1:0]  shadow_gap = kdq_pkg::GAP_RESET;

   rsp_item_type      step_rsps[$];
   rsp_item_type      rsp_forecast[$];
   rsp_item_type      rsp_want;
   plan_row_type      plan[$];
   logic [KEY_W-1:0]  key_pool [4];

   int mismatches = 0;
   int requests_sent = 0;
   int results_seen = 0;
   int due_seen = 0;
   int full_seen = 0;
   int idle_cycles = 0;

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_rank[i] = 0;
      end
   end

   task automatic note_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      mismatches++;
      $display("%0t mismatch on %s: got %0h, want %0h (result %0d)",
               $realtime, what, got, want, results_seen);
   endtask

   function automatic rsp_item_type mk_rsp(input kdq_pkg::status_type st, input logic cls,
                                           input logic [KEY_W-1:0] key,
                                           input logic [TAG_W-1:0] tag, input logic last);
      rsp_item_type r;
      r.status = st;
      r.cls = cls;
      r.key = key;
      r.tag = tag;
      r.last = last;
      return r;
   endfunction

   function automatic req_item_type mk_req(input kdq_pkg::req_code_type op, input logic cls,
                                           input logic [KEY_W-1:0] key,
                                           input logic [TAG_W-1:0] tag,
                                           input logic [TIME_W-1:0] delay,
                                           input logic [TIME_W-1:0] elapsed);
      req_item_type q;
      q.op = op;
      q.cls = cls;
      q.key = key;
      q.tag = tag;
      q.delay = delay;
      q.elapsed = elapsed;
      return q;
   endfunction

   function automatic plan_row_type mk_row(input req_item_type req, input int reps,
                                           input int typed_n, input rsp_item_type rsp);
      plan_row_type row;
      row.req = req;
      row.reps = reps;
      row.typed_n = typed_n;
      row.rsp = rsp;
      return row;
   endfunction

   function automatic void add_row(input plan_row_type row);
      plan = {plan, row};
   endfunction

   function automatic void owe_rsp(input rsp_item_type r);
      step_rsps = {step_rsps, r};
   endfunction

   // results the block owes for one accepted request, left in step_rsps
   function automatic void forecast_step(input req_item_type it);
      int slot;
      int count;
      int n;
      logic [TIME_W:0] sum;
      logic [TIME_W-1:0] dly;
      logic hit [DEPTH];
      int rerank [DEPTH];
      rsp_item_type tail;
      step_rsps.delete();
      case (it.op)
         kdq_pkg::REQ_INSERT: begin
            slot = -1;
            count = 0;
            dly = it.delay;
            for (int i = 0; i < DEPTH; i++) begin
               if (!shadow_valid[i]) begin
                  if (slot < 0) slot = i;
               end else begin
                  count++;
                  if (it.cls && shadow_kind[i] && shadow_key[i] == it.key) begin
                     sum = {1'b0, shadow_left[i]} + {{(TIME_W+1-GAP_W){1'b0}}, shadow_gap};
                     if (sum > {1'b0, TIME_MAX}) sum = {1'b0, TIME_MAX};
                     if (sum[TIME_W-1:0] > dly) dly = sum[TIME_W-1:0];
                  end
               end
            end
            if (slot < 0) begin
               owe_rsp(mk_rsp(kdq_pkg::ST_FULL, 1'b0, '0, '0, 1'b1));
            end else begin
               shadow_valid[slot] = 1'b1;
               shadow_kind[slot] = it.cls;
               shadow_key[slot] = it.key;
               shadow_tag[slot] = it.tag;
               shadow_left[slot] = dly;
               shadow_rank[slot] = count;
               owe_rsp(mk_rsp(kdq_pkg::ST_ACCEPTED, 1'b0, '0, '0, 1'b1));
            end
         end
         kdq_pkg::REQ_TICK: begin
            n = 0;
            for (int i = 0; i < DEPTH; i++)
               hit[i] = shadow_valid[i] && shadow_left[i] <= it.elapsed;
            // operations before triggers, oldest first within each class
            for (int c = 1; c >= 0; c--)
               for (int r = 0; r < DEPTH; r++)
                  for (int i = 0; i < DEPTH; i++)
                     if (hit[i] && shadow_kind[i] == c[0] && shadow_rank[i] == r) begin
                        owe_rsp(mk_rsp(kdq_pkg::ST_DUE, shadow_kind[i], shadow_key[i],
                                       shadow_tag[i], 1'b0));
                        n++;
                     end
            for (int i = 0; i < DEPTH; i++) begin
               if (hit[i]) shadow_valid[i] = 1'b0;
               else if (shadow_valid[i]) shadow_left[i] = shadow_left[i] - it.elapsed;
            end
            for (int i = 0; i < DEPTH; i++) begin
               rerank[i] = 0;
               if (shadow_valid[i])
                  for (int j = 0; j < DEPTH; j++)
                     if (shadow_valid[j] && shadow_rank[j] < shadow_rank[i]) rerank[i]++;
            end
            for (int i = 0; i < DEPTH; i++)
               shadow_rank[i] = shadow_valid[i] ? rerank[i] : 0;
            if (n == 0) begin
               owe_rsp(mk_rsp(kdq_pkg::ST_NONE, 1'b0, '0, '0, 1'b1));
            end else begin
               tail = step_rsps[n-1];
               tail.last = 1'b1;
               step_rsps[n-1] = tail;
            end
         end
         kdq_pkg::REQ_CLEAR: begin
            for (int i = 0; i < DEPTH; i++) shadow_valid[i] = 1'b0;
            owe_rsp(mk_rsp(kdq_pkg::ST_CLEARED, 1'b0, '0, '0, 1'b1));
         end
         default: ;
      endcase
   endfunction

   function automatic req_item_type rand_request();
      req_item_type q;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) q.op = kdq_pkg::REQ_INSERT;
      else if (pick < 88) q.op = kdq_pkg::REQ_TICK;
      else if (pick < 94) q.op = kdq_pkg::REQ_CLEAR;
      else q.op = kdq_pkg::REQ_NONE;
      q.cls = 1'($urandom_range(0, 1));
      // a small key pool keeps same-key spacing busy
      if ($urandom_range(0, 9) < 7) q.key = key_pool[$urandom_range(0, 3)];
      else q.key = $urandom;
      q.tag = TAG_W'($urandom);
      case ($urandom_range(0, 9))
         0: q.delay = '0;
         1: q.delay = TIME_MAX - TIME_W'($urandom_range(0, 3000));
         2: q.delay = TIME_W'($urandom);
         default: q.delay = TIME_W'($urandom_range(0, 4000));
      endcase
      case ($urandom_range(0, 9))
         0: q.elapsed = '0;
         1: q.elapsed = TIME_MAX;
         2: q.elapsed = TIME_W'($urandom);
         default: q.elapsed = TIME_W'($urandom_range(0, 2500));
      endcase
      return q;
   endfunction

   // drive one request and hold it until the transfer, then predict it
   task automatic issue(input req_item_type it);
      req_type <= it.op;
      req_entry_class <= it.cls;
      req_entry_key <= it.key;
      req_entry_tag <= it.tag;
      req_delay_ms <= it.delay;
      req_elapsed_ms <= it.elapsed;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      requests_sent++;
      forecast_step(it);
   endtask

   task automatic take_break(input logic allow);
      if (allow && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (rsp_forecast.size() != 0 || busy) @(posedge clock);
      repeat (CSR_PAD) @(posedge clock);
   endtask

   task automatic csr_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == GAP_ADDR) shadow_gap = data[GAP_W-1:0];
      @(posedge clock);
   endtask

   task automatic csr_check_gap();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= GAP_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {{(32-GAP_W){1'b0}}, shadow_gap})
         note_mismatch("gap readback", prdata, {{(32-GAP_W){1'b0}}, shadow_gap});
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // result checker: every strobe is one transfer
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (rsp_forecast.size() == 0) begin
            note_mismatch("result with nothing pending", rsp_status, '0);
         end else begin
            rsp_want = rsp_forecast.pop_front();
            if (rsp_status !== rsp_want.status)
               note_mismatch("status", rsp_status, rsp_want.status);
            if (rsp_due_class !== rsp_want.cls)
               note_mismatch("due_class", rsp_due_class, rsp_want.cls);
            if (rsp_due_key !== rsp_want.key)
               note_mismatch("due_key", rsp_due_key, rsp_want.key);
            if (rsp_due_tag !== rsp_want.tag)
               note_mismatch("due_tag", rsp_due_tag, rsp_want.tag);
            if (rsp_last_result !== rsp_want.last)
               note_mismatch("last_result", rsp_last_result, rsp_want.last);
            if (rsp_want.status == kdq_pkg::ST_DUE) due_seen++;
            if (rsp_want.status == kdq_pkg::ST_FULL) full_seen++;
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe === 1'b1 || (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      req_item_type it;
      rsp_item_type no_rsp;
      logic [GAP_W-1:0] gaps [PHASES];
      logic last_phase;
      int sent;
      reset <= 1'b1;
      start <= 1'b0;
      req_type <= kdq_pkg::REQ_NONE;
      req_entry_class <= 1'b0;
      req_entry_key <= '0;
      req_entry_tag <= '0;
      req_delay_ms <= '0;
      req_elapsed_ms <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = 32'h1;
      key_pool[3] = $urandom;
      gaps[0] = '0;
      gaps[1] = '1;
      gaps[2] = GAP_W'($urandom_range(1, 5000));
      gaps[3] = 16'd3;
      gaps[4] = kdq_pkg::GAP_RESET;
      no_rsp = mk_rsp(kdq_pkg::ST_ACCEPTED, 1'b0, '0, '0, 1'b0);

      // empty table, extremes, zero delay, spacing with saturation, ignored code
      add_row(mk_row(mk_req(kdq_pkg::REQ_TICK, 0, 0, 0, 0, 0), 1, 1,
                     mk_rsp(kdq_pkg::ST_NONE, 0, 0, 0, 1)));
      add_row(mk_row(mk_req(kdq_pkg::REQ_CLEAR, 0, 0, 0, 0, 0), 1, 1,
                     mk_rsp(kdq_pkg::ST_CLEARED, 0, 0, 0, 1)));
      add_row(mk_row(mk_req(kdq_pkg::REQ_INSERT, 0, '1, '1, 0, '1), 1, 1,
                     mk_rsp(kdq_pkg::ST_ACCEPTED, 0, 0, 0, 1)));
      add_row(mk_row(mk_req(kdq_pkg::REQ_TICK, 0, 0, 0, '1, 0), 1, 1,
                     mk_rsp(kdq_pkg::ST_DUE, 0, '1, '1, 1)));
      add_row(mk_row(mk_req(kdq_pkg::REQ_INSERT, 1, 0, 0, TIME_MAX, 0), 1, 1,
                     mk_rsp(kdq_pkg::ST_ACCEPTED, 0, 0, 0, 1)));
      add_row(mk_row(mk_req(kdq_pkg::REQ_INSERT, 1, 0, 1, 0, 0), 1, 1,
                     mk_rsp(kdq_pkg::ST_ACCEPTED, 0, 0, 0, 1)));
      add_row(mk_row(mk_req(kdq_pkg::REQ_INSERT, 0, 0, 2, 10, 0), 1, -1, no_rsp));
      add_row(mk_row(mk_req(kdq_pkg::REQ_INSERT, 1, 1, 3, 20, 0), 1, -1, no_rsp));
      add_row(mk_row(mk_req(kdq_pkg::REQ_TICK, 0, 0, 0, 0, TIME_MAX - 24'd1), 1, -1,
                     no_rsp));
      add_row(mk_row(mk_req(kdq_pkg::REQ_TICK, 1, '1, '1, '1, 1), 1, -1, no_rsp));
      add_row(mk_row(mk_req(kdq_pkg::REQ_NONE, 1, '1, '1, '1, '1), 1, 0, no_rsp));
      // fill the table: spaced operations and plain triggers on one key
      add_row(mk_row(mk_req(kdq_pkg::REQ_INSERT, 1, 7, 16'h100, 100, 0), 8, -1, no_rsp));
      add_row(mk_row(mk_req(kdq_pkg::REQ_INSERT, 0, 7, 16'h200, 5000, 0), 8, -1, no_rsp));
      add_row(mk_row(mk_req(kdq_pkg::REQ_TICK, 0, 0, 0, 0, 50), 1, 1,
                     mk_rsp(kdq_pkg::ST_NONE, 0, 0, 0, 1)));
      add_row(mk_row(mk_req(kdq_pkg::REQ_INSERT, 1, 7, 16'h300, 0, 0), 1, 1,
                     mk_rsp(kdq_pkg::ST_FULL, 0, 0, 0, 1)));
      add_row(mk_row(mk_req(kdq_pkg::REQ_TICK, 0, 0, 0, 0, 65535), 1, -1, no_rsp));
      add_row(mk_row(mk_req(kdq_pkg::REQ_INSERT, 1, 9, 16'h400, 3, 0), 1, -1, no_rsp));
      add_row(mk_row(mk_req(kdq_pkg::REQ_CLEAR, 1, '1, '1, '1, '1), 1, 1,
                     mk_rsp(kdq_pkg::ST_CLEARED, 0, 0, 0, 1)));
      add_row(mk_row(mk_req(kdq_pkg::REQ_TICK, 0, 0, 0, 0, TIME_MAX), 1, 1,
                     mk_rsp(kdq_pkg::ST_NONE, 0, 0, 0, 1)));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      csr_check_gap();

      foreach (plan[r]) begin
         for (int k = 0; k < plan[r].reps; k++) begin
            it = plan[r].req;
            it.tag = it.tag + TAG_W'(k);
            issue(it);
            if (plan[r].typed_n < 0) begin
               rsp_forecast = {rsp_forecast, step_rsps};
            end else if (plan[r].typed_n == 1) begin
               rsp_forecast = {rsp_forecast, plan[r].rsp};
            end
            take_break(1'b1);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         drain();
         if (p == 2) begin
            // a write outside the register map must leave the gap alone
            csr_write(SPARE_ADDR, $urandom);
            csr_check_gap();
         end
         csr_write(GAP_ADDR, {16'($urandom), gaps[p]});
         csr_check_gap();
         last_phase = (p == PHASES - 1);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            it = rand_request();
            issue(it);
            rsp_forecast = {rsp_forecast, step_rsps};
            if (it.op != kdq_pkg::REQ_NONE) sent++;
            if (!last_phase && $urandom_range(0, 59) == 0) drain();
            else take_break(!last_phase);
         end
      end

      start <= 1'b0;
      while (rsp_forecast.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run: %0d requests over %0d gap settings, %0d results checked",
               requests_sent, PHASES + 1, results_seen);
      $display("run: %0d due entries, %0d full rejects, %0d mismatches",
               due_seen, full_seen, mismatches);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
